// ===== src/iir3s_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the third-order symmetric iir filter
package iir3s_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int COEF_WIDTH    = 32;
    localparam int COEF_INT_BITS = 4;

    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd4;

endpackage

// ===== src/iir3s_coef_regs.sv =====
`timescale 1ns / 1ps
// coefficient register bank written through the configuration port
module iir3s_coef_regs #(
    parameter int COEF_WIDTH = iir3s_pkg::COEF_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [iir3s_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_WIDTH-1:0]             cfg_data,
    output logic signed [COEF_WIDTH-1:0]      coef_a0,
    output logic signed [COEF_WIDTH-1:0]      coef_a1,
    output logic signed [COEF_WIDTH-1:0]      coef_b1,
    output logic signed [COEF_WIDTH-1:0]      coef_b2,
    output logic signed [COEF_WIDTH-1:0]      coef_b3
);

    logic [COEF_WIDTH-1:0] a0_reg;
    logic [COEF_WIDTH-1:0] a1_reg;
    logic [COEF_WIDTH-1:0] b1_reg;
    logic [COEF_WIDTH-1:0] b2_reg;
    logic [COEF_WIDTH-1:0] b3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg <= '0;
            a1_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
            b3_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iir3s_pkg::REG_A0: a0_reg <= cfg_data;
                iir3s_pkg::REG_A1: a1_reg <= cfg_data;
                iir3s_pkg::REG_B1: b1_reg <= cfg_data;
                iir3s_pkg::REG_B2: b2_reg <= cfg_data;
                iir3s_pkg::REG_B3: b3_reg <= cfg_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    assign coef_a0 = $signed(a0_reg);
    assign coef_a1 = $signed(a1_reg);
    assign coef_b1 = $signed(b1_reg);
    assign coef_b2 = $signed(b2_reg);
    assign coef_b3 = $signed(b3_reg);

endmodule

// ===== src/iir3s_datapath.sv =====
`timescale 1ns / 1ps
// folded multiply-accumulate with rounding and saturation for one sample
module iir3s_datapath #(
    parameter int SAMPLE_WIDTH = iir3s_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = iir3s_pkg::COEF_WIDTH
) (
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic signed [SAMPLE_WIDTH-1:0] x1,
    input  logic signed [SAMPLE_WIDTH-1:0] x2,
    input  logic signed [SAMPLE_WIDTH-1:0] x3,
    input  logic signed [SAMPLE_WIDTH-1:0] y1,
    input  logic signed [SAMPLE_WIDTH-1:0] y2,
    input  logic signed [SAMPLE_WIDTH-1:0] y3,
    input  logic signed [COEF_WIDTH-1:0]   coef_a0,
    input  logic signed [COEF_WIDTH-1:0]   coef_a1,
    input  logic signed [COEF_WIDTH-1:0]   coef_b1,
    input  logic signed [COEF_WIDTH-1:0]   coef_b2,
    input  logic signed [COEF_WIDTH-1:0]   coef_b3,
    output logic signed [SAMPLE_WIDTH-1:0] y
);

    localparam int FRAC   = COEF_WIDTH - iir3s_pkg::COEF_INT_BITS;
    localparam int FF_W   = COEF_WIDTH + SAMPLE_WIDTH + 1;
    localparam int FB_W   = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W  = COEF_WIDTH + SAMPLE_WIDTH + 4;
    localparam int SH_W   = ACC_W - FRAC;
    localparam int TOP_W  = SH_W - SAMPLE_WIDTH + 1;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC - 1);
    localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH:0] outer_sum;
    logic signed [SAMPLE_WIDTH:0] inner_sum;
    logic signed [FF_W-1:0]       prod_outer;
    logic signed [FF_W-1:0]       prod_inner;
    logic signed [FB_W-1:0]       prod_b1;
    logic signed [FB_W-1:0]       prod_b2;
    logic signed [FB_W-1:0]       prod_b3;
    logic [ACC_W-1:0]             acc;
    logic [SH_W-1:0]              shifted;
    logic [TOP_W-1:0]             top_bits;
    logic                         in_range;

    // symmetric numerator: fold the input pairs before multiplying
    assign outer_sum = {x[SAMPLE_WIDTH-1], x} + {x3[SAMPLE_WIDTH-1], x3};
    assign inner_sum = {x1[SAMPLE_WIDTH-1], x1} + {x2[SAMPLE_WIDTH-1], x2};

    assign prod_outer = coef_a0 * outer_sum;
    assign prod_inner = coef_a1 * inner_sum;
    assign prod_b1    = coef_b1 * y1;
    assign prod_b2    = coef_b2 * y2;
    assign prod_b3    = coef_b3 * y3;

    // exact accumulation, wide enough that nothing wraps
    assign acc = {{(ACC_W-FF_W){prod_outer[FF_W-1]}}, prod_outer}
               + {{(ACC_W-FF_W){prod_inner[FF_W-1]}}, prod_inner}
               - {{(ACC_W-FB_W){prod_b1[FB_W-1]}}, prod_b1}
               - {{(ACC_W-FB_W){prod_b2[FB_W-1]}}, prod_b2}
               - {{(ACC_W-FB_W){prod_b3[FB_W-1]}}, prod_b3}
               + ROUND_BIAS;

    // arithmetic shift by the fraction width is just dropping the low bits
    assign shifted  = acc[ACC_W-1:FRAC];
    assign top_bits = shifted[SH_W-1:SAMPLE_WIDTH-1];
    assign in_range = (&top_bits) || !(|top_bits);

    always_comb
    begin
        if (in_range)
        begin
            y = $signed(shifted[SAMPLE_WIDTH-1:0]);
        end
        else if (shifted[SH_W-1])
        begin
            y = $signed(SAT_MIN);
        end
        else
        begin
            y = $signed(SAT_MAX);
        end
    end

endmodule

// ===== src/third_order_iir_symmetric_filter_unit.sv =====
`timescale 1ns / 1ps
// top level: third-order symmetric-numerator iir filter with valid/ready streams
// path: an accepted word waits in x_reg; its result is registered into y1_reg
// throughput: one word per cycle while out_ready is high; the feedback loop
//   closes through the single registered pass from x_reg to the output history
// reset: coefficients, input and output histories cleared, no word in flight
module third_order_iir_symmetric_filter_unit #(
    parameter int SAMPLE_WIDTH = iir3s_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = iir3s_pkg::COEF_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [iir3s_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]           cfg_data,
    // input word stream
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    // output word stream
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  filtered_sample
);

    logic signed [COEF_WIDTH-1:0] coef_a0;
    logic signed [COEF_WIDTH-1:0] coef_a1;
    logic signed [COEF_WIDTH-1:0] coef_b1;
    logic signed [COEF_WIDTH-1:0] coef_b2;
    logic signed [COEF_WIDTH-1:0] coef_b3;

    // input register (one word deep)
    logic                           in_full_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;

    // filter histories; y1 doubles as the output register
    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x3_reg;
    logic signed [SAMPLE_WIDTH-1:0] y1_reg;
    logic signed [SAMPLE_WIDTH-1:0] y2_reg;
    logic signed [SAMPLE_WIDTH-1:0] y3_reg;
    logic                           out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic                           advance;
    logic                           in_take;

    iir3s_coef_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_a0   (coef_a0),
        .coef_a1   (coef_a1),
        .coef_b1   (coef_b1),
        .coef_b2   (coef_b2),
        .coef_b3   (coef_b3)
    );

    iir3s_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .x       (x_reg),
        .x1      (x1_reg),
        .x2      (x2_reg),
        .x3      (x3_reg),
        .y1      (y1_reg),
        .y2      (y2_reg),
        .y3      (y3_reg),
        .coef_a0 (coef_a0),
        .coef_a1 (coef_a1),
        .coef_b1 (coef_b1),
        .coef_b2 (coef_b2),
        .coef_b3 (coef_b3),
        .y       (y_next)
    );

    // the held word moves on once the output slot is free or being drained
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    // input slot takes a new word when empty or emptying this cycle
    assign in_ready = !in_full_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // payload of the input slot, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= sample_in;
        end
    end

    // histories shift on every filtered word; the new output lands in y1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            x3_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
            y3_reg <= '0;
        end
        else if (advance)
        begin
            x1_reg <= x_reg;
            x2_reg <= x1_reg;
            x3_reg <= x2_reg;
            y1_reg <= y_next;
            y2_reg <= y1_reg;
            y3_reg <= y2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = y1_reg;

endmodule
